### rtl/itf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_pkg: shared types, constants and microcode program
// Conversion codes, character codes, control word layout and the read-only
// program that the step sequencer runs for every value.
// ----------------------------------------------------------------------------
package itf_pkg;

    // Field width saturates here
    localparam int MAX_WIDTH = 64;
    localparam int PAD_W     = $clog2(MAX_WIDTH + 1);

    // Longest digit string: octal of a 32-bit value
    localparam int MAX_DIGITS = 11;
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Conversion codes
    localparam logic [2:0] CONV_SDEC  = 3'd0;
    localparam logic [2:0] CONV_UDEC  = 3'd1;
    localparam logic [2:0] CONV_LHEX  = 3'd2;
    localparam logic [2:0] CONV_UHEX  = 3'd3;
    localparam logic [2:0] CONV_OCT   = 3'd4;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_OCT
    } base_t;

    // Datapath action of one step
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_DIV,
        ACT_REM,
        ACT_SIZE,
        ACT_EMIT_SPACE,
        ACT_EMIT_MINUS,
        ACT_EMIT_ZERO,
        ACT_EMIT_X,
        ACT_EMIT_ZPAD,
        ACT_EMIT_DIGIT
    } act_t;

    // Jump condition of one step: true jumps to target, false falls through
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_MORE_DIGITS,
        C_NO_SPACE,
        C_PAD_LEFT,
        C_NOT_NEG,
        C_NOT_PRE,
        C_NO_ZEROPAD,
        C_DIGITS_LEFT
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_DIV   = 4'd1;
    localparam step_t STEP_REM   = 4'd2;
    localparam step_t STEP_SIZE  = 4'd3;
    localparam step_t STEP_TSPC  = 4'd4;
    localparam step_t STEP_SPC   = 4'd5;
    localparam step_t STEP_TNEG  = 4'd6;
    localparam step_t STEP_NEG   = 4'd7;
    localparam step_t STEP_TPRE  = 4'd8;
    localparam step_t STEP_PRE0  = 4'd9;
    localparam step_t STEP_PREX  = 4'd10;
    localparam step_t STEP_TZPD  = 4'd11;
    localparam step_t STEP_ZPD   = 4'd12;
    localparam step_t STEP_DIG   = 4'd13;
    localparam step_t STEP_DONE  = 4'd14;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Status from the datapath that the jump conditions test
    typedef struct packed {
        logic req_valid;
        logic emit_ok;
        logic q_nonzero;
        logic no_space;
        logic pad_left;
        logic not_neg;
        logic not_pre;
        logic no_zeropad;
        logic digits_left;
    } itf_status_t;

    // Microcode ROM
    function automatic ctrl_word_t program_word(input step_t pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_IDLE: w = '{ACT_LOAD,       C_NO_REQ,      STEP_IDLE};
            STEP_DIV:  w = '{ACT_DIV,        C_NEVER,       STEP_IDLE};
            STEP_REM:  w = '{ACT_REM,        C_MORE_DIGITS, STEP_DIV};
            STEP_SIZE: w = '{ACT_SIZE,       C_NEVER,       STEP_IDLE};
            STEP_TSPC: w = '{ACT_NOP,        C_NO_SPACE,    STEP_TNEG};
            STEP_SPC:  w = '{ACT_EMIT_SPACE, C_PAD_LEFT,    STEP_SPC};
            STEP_TNEG: w = '{ACT_NOP,        C_NOT_NEG,     STEP_TPRE};
            STEP_NEG:  w = '{ACT_EMIT_MINUS, C_NEVER,       STEP_IDLE};
            STEP_TPRE: w = '{ACT_NOP,        C_NOT_PRE,     STEP_TZPD};
            STEP_PRE0: w = '{ACT_EMIT_ZERO,  C_NEVER,       STEP_IDLE};
            STEP_PREX: w = '{ACT_EMIT_X,     C_NEVER,       STEP_IDLE};
            STEP_TZPD: w = '{ACT_NOP,        C_NO_ZEROPAD,  STEP_DIG};
            STEP_ZPD:  w = '{ACT_EMIT_ZPAD,  C_PAD_LEFT,    STEP_ZPD};
            STEP_DIG:  w = '{ACT_EMIT_DIGIT, C_DIGITS_LEFT, STEP_DIG};
            STEP_DONE: w = '{ACT_NOP,        C_ALWAYS,      STEP_IDLE};
            default:   w = '{ACT_NOP,        C_ALWAYS,      STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic is_emit(input act_t a);
        logic r;
        case (a) inside
            ACT_EMIT_SPACE, ACT_EMIT_MINUS, ACT_EMIT_ZERO, ACT_EMIT_X,
            ACT_EMIT_ZPAD, ACT_EMIT_DIGIT: r = 1'b1;
            default:                       r = 1'b0;
        endcase
        return r;
    endfunction

    // ASCII for one digit, "0123456789abcdef" or "0123456789ABCDEF"
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + 8'(d);
        else if (upper)
            c = CH_UPPER_A + 8'(d - 4'd10);
        else
            c = CH_LOWER_A + 8'(d - 4'd10);
        return c;
    endfunction

endpackage

### rtl/itf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_if: request and character channels
// Valid/ready channels for the formatting request and the emitted characters.
// ----------------------------------------------------------------------------
interface itf_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [2:0]  conversion;
    logic [6:0]  field_width;
    logic        zero_pad;
    logic        hex_prefix;

    modport source (output valid, value, conversion, field_width, zero_pad, hex_prefix,
                    input ready);
    modport sink   (input valid, value, conversion, field_width, zero_pad, hex_prefix,
                    output ready);
endinterface

interface itf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

### rtl/itf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_seq: microcode step sequencer
// Step counter over the program ROM with conditional jumps; holds on emit
// steps while the character register is full and not being drained.
// ----------------------------------------------------------------------------
module itf_seq
    import itf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  itf_status_t status,
    output act_t        act
);

    step_t      pc_reg;
    step_t      pc_next;
    ctrl_word_t word;
    logic       cond_true;
    logic       hold;

    always_comb
    begin
        word = program_word(pc_reg);
        unique case (word.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_REQ:      cond_true = !status.req_valid;
            C_MORE_DIGITS: cond_true = status.q_nonzero;
            C_NO_SPACE:    cond_true = status.no_space;
            C_PAD_LEFT:    cond_true = status.pad_left;
            C_NOT_NEG:     cond_true = status.not_neg;
            C_NOT_PRE:     cond_true = status.not_pre;
            C_NO_ZEROPAD:  cond_true = status.no_zeropad;
            C_DIGITS_LEFT: cond_true = status.digits_left;
            default:       cond_true = 1'b1;
        endcase
        // stall an emit step until the character register frees up
        hold = is_emit(word.act) && !status.emit_ok;
        if (hold)
            pc_next = pc_reg;
        else if (cond_true)
            pc_next = word.target;
        else
            pc_next = pc_reg + step_t'(1);
        act = word.act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

### rtl/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter: printf-style integer to ASCII text
// Converts a 32-bit value to decimal, hex or octal text with field width,
// sign, prefix and padding, one character per output request.
// ----------------------------------------------------------------------------
// Flow: a new value is taken only after every character of the last one, the larger
//   of width and text length in number, has entered the character register; digit
//   extraction takes two steps per digit (divide: reciprocal multiply for decimal,
//   shift otherwise; then remainder).
// Reset: step counter returns to the idle step, character register empties;
//   digit store and payload registers are not reset.
module integer_to_text_formatter
    import itf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    itf_req_if.sink     number,
    itf_char_if.source  text
);

    act_t        act;
    itf_status_t status;

    // Request registers
    logic [31:0]          val_reg,   val_next;
    logic [31:0]          q_reg,     q_next;
    base_t                base_reg,  base_next;
    logic                 upper_reg, upper_next;
    logic                 neg_reg,   neg_next;
    logic                 pre_reg,   pre_next;
    logic                 zpad_reg,  zpad_next;
    logic [PAD_W-1:0]     width_reg, width_next;
    logic [PAD_W-1:0]     pad_reg,   pad_next;
    logic [DIG_CNT_W-1:0] dcnt_reg,  dcnt_next;

    // Digit store, least significant digit at index 0
    logic [3:0]           digit_mem [MAX_DIGITS];

    // Character register
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           char_reg,   char_next;
    logic                 last_reg,   last_next;

    logic                 accept;
    logic                 emit_ok;
    logic                 out_load;
    logic [63:0]          prod;
    logic [3:0]           rem_digit;
    logic [3:0]           q_times_ten;
    logic [PAD_W-1:0]     body;
    logic [DIG_IDX_W-1:0] rd_idx;
    logic [31:0]          mag;
    logic                 is_neg;
    logic                 is_hex;

    itf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .act    (act)
    );

    assign number.ready = (act == ACT_LOAD);
    assign accept       = number.valid && number.ready;

    // Emit only into an empty register or one being drained this cycle
    assign emit_ok  = !ovalid_reg || text.ready;
    assign out_load = is_emit(act) && emit_ok;

    // Reciprocal multiply for divide by ten; remainder from low bits only
    assign prod        = 64'(val_reg) * 64'(RECIP_TEN);
    assign q_times_ten = {q_reg[2:0], 1'b0} + {q_reg[0], 3'b000};
    assign rd_idx      = DIG_IDX_W'(dcnt_reg - DIG_CNT_W'(1));

    assign is_neg = (number.conversion == CONV_SDEC) && number.value[31];
    assign is_hex = (number.conversion == CONV_LHEX) || (number.conversion == CONV_UHEX);
    assign mag    = is_neg ? (32'd0 - number.value) : number.value;

    assign body = PAD_W'(dcnt_reg) + PAD_W'(neg_reg) + PAD_W'({pre_reg, 1'b0});

    always_comb
    begin
        status.req_valid   = number.valid;
        status.emit_ok     = emit_ok;
        status.q_nonzero   = (q_reg != 32'd0);
        status.no_space    = zpad_reg || (pad_reg == '0);
        status.pad_left    = (pad_reg != PAD_W'(1));
        status.not_neg     = !neg_reg;
        status.not_pre     = !pre_reg;
        status.no_zeropad  = !zpad_reg || (pad_reg == '0);
        status.digits_left = (dcnt_reg != DIG_CNT_W'(1));
    end

    always_comb
    begin
        case (base_reg)
            BASE_HEX: rem_digit = val_reg[3:0];
            BASE_OCT: rem_digit = {1'b0, val_reg[2:0]};
            default:  rem_digit = val_reg[3:0] - q_times_ten;
        endcase
    end

    // Datapath next state, selected by the current step's action
    always_comb
    begin
        val_next   = val_reg;
        q_next     = q_reg;
        base_next  = base_reg;
        upper_next = upper_reg;
        neg_next   = neg_reg;
        pre_next   = pre_reg;
        zpad_next  = zpad_reg;
        width_next = width_reg;
        pad_next   = pad_reg;
        dcnt_next  = dcnt_reg;
        char_next  = char_reg;
        last_next  = 1'b0;

        unique case (act) inside
            ACT_LOAD:
            begin
                if (accept)
                begin
                    val_next   = mag;
                    neg_next   = is_neg;
                    upper_next = (number.conversion == CONV_UHEX);
                    pre_next   = is_hex && number.hex_prefix && (number.value != 32'd0);
                    zpad_next  = number.zero_pad;
                    dcnt_next  = '0;
                    if (is_hex)
                        base_next = BASE_HEX;
                    else if (number.conversion == CONV_OCT)
                        base_next = BASE_OCT;
                    else
                        base_next = BASE_DEC;
                    // saturate the requested width
                    if (number.field_width > 7'(MAX_WIDTH))
                        width_next = PAD_W'(MAX_WIDTH);
                    else
                        width_next = PAD_W'(number.field_width);
                end
            end
            ACT_DIV:
            begin
                case (base_reg)
                    BASE_HEX: q_next = val_reg >> 4;
                    BASE_OCT: q_next = val_reg >> 3;
                    default:  q_next = 32'(prod >> RECIP_SHIFT);
                endcase
            end
            ACT_REM:
            begin
                val_next  = q_reg;
                dcnt_next = dcnt_reg + DIG_CNT_W'(1);
            end
            ACT_SIZE:
            begin
                pad_next = (width_reg > body) ? (width_reg - body) : '0;
            end
            ACT_EMIT_SPACE, ACT_EMIT_ZPAD:
            begin
                if (emit_ok)
                begin
                    pad_next  = pad_reg - PAD_W'(1);
                    char_next = (act == ACT_EMIT_SPACE) ? CH_SPACE : CH_ZERO;
                end
            end
            ACT_EMIT_MINUS:
            begin
                if (emit_ok)
                    char_next = CH_MINUS;
            end
            ACT_EMIT_ZERO:
            begin
                if (emit_ok)
                    char_next = CH_ZERO;
            end
            ACT_EMIT_X:
            begin
                if (emit_ok)
                    char_next = upper_reg ? CH_UPPER_X : CH_LOWER_X;
            end
            ACT_EMIT_DIGIT:
            begin
                // digits run most significant first and always close the text
                if (emit_ok)
                begin
                    char_next = digit_char(digit_mem[rd_idx], upper_reg);
                    last_next = (dcnt_reg == DIG_CNT_W'(1));
                    dcnt_next = dcnt_reg - DIG_CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
            ovalid_next = 1'b1;
        else if (text.ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            dcnt_reg   <= '0;
            pad_reg    <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            dcnt_reg   <= dcnt_next;
            pad_reg    <= pad_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        q_reg     <= q_next;
        base_reg  <= base_next;
        upper_reg <= upper_next;
        neg_reg   <= neg_next;
        pre_reg   <= pre_next;
        zpad_reg  <= zpad_next;
        width_reg <= width_next;
        if (out_load)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    // Digit store write
    always_ff @(posedge clk)
    begin
        if (act == ACT_REM)
            digit_mem[dcnt_reg[DIG_IDX_W-1:0]] <= rem_digit;
    end

    assign text.valid     = ovalid_reg;
    assign text.char_code = char_reg;
    assign text.last_char = last_reg;

    // Digit count never runs past the store
    a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DIG_CNT_W'(MAX_DIGITS))
        else $error("digit count beyond digit store");

    // A new request starts with an empty digit store
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> dcnt_reg == '0)
        else $error("digit count not cleared on request");

    // The final character leaves no digit behind
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> dcnt_reg == '0)
        else $error("last character emitted with digits pending");

    // Extraction never writes past the last entry
    a_rem_room: assert property (@(posedge clk) disable iff (!rst_n)
        act == ACT_REM |-> dcnt_reg < DIG_CNT_W'(MAX_DIGITS))
        else $error("digit written beyond store");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: integer_to_text_formatter testbench
// Sends formatting requests through the number channel and checks every
// character on the text channel against text rendered locally from the same
// request. Directed corners come first, then random requests under random
// back-pressure and sender gaps.
// ----------------------------------------------------------------------------
import itf_pkg::*;

typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
} text_char_t;

// Renders requests into the characters they must produce and checks the
// characters the block returns, oldest first.
class formatted_text;
    text_char_t  pending_chars[$];
    int unsigned mismatches;
    int unsigned chars_checked;

    function new();
        mismatches    = 0;
        chars_checked = 0;
    endfunction

    function void render_request(input logic [31:0] value, input logic [2:0] conversion,
                                 input logic [6:0] field_width, input logic zero_pad,
                                 input logic hex_prefix);
        text_char_t  line[$];
        logic [7:0]  digits[$];
        logic [31:0] magnitude;
        logic [31:0] radix;
        string       glyphs;
        int unsigned width;
        int unsigned body;
        int unsigned pad;
        logic        upper;
        logic        negative;
        logic        prefixed;

        width     = (field_width > MAX_WIDTH) ? MAX_WIDTH : field_width;
        magnitude = value;
        radix     = 32'd10;
        upper     = 1'b0;
        negative  = 1'b0;
        prefixed  = 1'b0;
        case (conversion) inside
            CONV_SDEC:
            begin
                if (value[31])
                begin
                    negative  = 1'b1;
                    magnitude = 32'd0 - value;
                end
            end
            CONV_LHEX, CONV_UHEX:
            begin
                radix    = 32'd16;
                upper    = (conversion == CONV_UHEX);
                prefixed = hex_prefix && (value != 32'd0);
            end
            CONV_OCT:
                radix = 32'd8;
            default: ;
        endcase

        glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
        do
        begin
            digits.push_front(glyphs[int'(magnitude % radix)]);
            magnitude = magnitude / radix;
        end
        while (magnitude != 32'd0);

        body = digits.size() + (negative ? 1 : 0) + (prefixed ? 2 : 0);
        pad  = (width > body) ? width - body : 0;
        if (!zero_pad)
            repeat (pad) line.push_back(text_char_t'{CH_SPACE, 1'b0});
        if (negative)
            line.push_back(text_char_t'{CH_MINUS, 1'b0});
        if (prefixed)
        begin
            line.push_back(text_char_t'{CH_ZERO, 1'b0});
            line.push_back(text_char_t'{upper ? CH_UPPER_X : CH_LOWER_X, 1'b0});
        end
        if (zero_pad)
            repeat (pad) line.push_back(text_char_t'{CH_ZERO, 1'b0});
        foreach (digits[i])
            line.push_back(text_char_t'{digits[i], 1'b0});
        line[line.size() - 1].last_char = 1'b1;
        foreach (line[i])
            pending_chars.push_back(line[i]);
    endfunction

    function void check_char(input logic [7:0] char_code, input logic last_char);
        text_char_t want;

        chars_checked++;
        if (pending_chars.size() == 0)
        begin
            $error("char with nothing pending: char_code 0x%02h last_char %0b",
                   char_code, last_char);
            mismatches++;
            return;
        end
        want = pending_chars.pop_front();
        if (char_code !== want.char_code)
        begin
            $error("char_code: expected 0x%02h, actual 0x%02h", want.char_code, char_code);
            mismatches++;
        end
        if (last_char !== want.last_char)
        begin
            $error("last_char: expected %0b, actual %0b", want.last_char, last_char);
            mismatches++;
        end
    endfunction
endclass

module tb;

    // Codes 5..7 are not named by the package; the block treats them as
    // unsigned decimal.
    localparam logic [2:0] CONV_SPARE5 = 3'd5;
    localparam logic [2:0] CONV_SPARE6 = 3'd6;
    localparam logic [2:0] CONV_SPARE7 = 3'd7;
    localparam logic [6:0] WIDTH_TOP   = 7'h7F;

    localparam int RANDOM_REQUESTS = 220;
    localparam int QUIET_TAIL      = 30;    // last requests run with no idling
    localparam int DRAIN_CYCLES    = 40;    // covers worst first-char latency
    localparam int STALL_LIMIT     = 3000;  // cycles with no handshake at all

    logic clk;
    logic rst_n;
    logic quiet_tail;
    logic sender_gappy;

    int unsigned idle_cycles;
    int unsigned requests_sent;
    int unsigned directed_sent;
    int unsigned full_width_sent;
    int unsigned conv_count[8];

    formatted_text formatted = new();

    itf_req_if  number_if ();
    itf_char_if text_if ();

    integer_to_text_formatter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if.sink),
        .text   (text_if.source)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Drive one request and hold it until the block takes it. Valid is left
    // high so a back-to-back request does not drop valid in between.
    task automatic send_number(input logic [31:0] value, input logic [2:0] conversion,
                               input logic [6:0] field_width, input logic zero_pad,
                               input logic hex_prefix);
        number_if.valid       <= 1'b1;
        number_if.value       <= value;
        number_if.conversion  <= conversion;
        number_if.field_width <= field_width;
        number_if.zero_pad    <= zero_pad;
        number_if.hex_prefix  <= hex_prefix;
        do
            @(posedge clk);
        while (!number_if.ready);
        formatted.render_request(value, conversion, field_width, zero_pad, hex_prefix);
        requests_sent++;
        conv_count[conversion]++;
        if (field_width >= MAX_WIDTH)
            full_width_sent++;
    endtask

    // Drop valid for a random burst, scribbling on the value meanwhile.
    task automatic pace_sender();
        if (!quiet_tail && sender_gappy && $urandom_range(0, 2) == 0)
        begin
            number_if.valid <= 1'b0;
            number_if.value <= $urandom();
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every pending character has come back.
    task automatic wait_text_drained();
        number_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (formatted.pending_chars.size() != 0);
    endtask

    task automatic send_random_number();
        logic [31:0] value;
        logic [2:0]  conversion;
        logic [6:0]  field_width;

        case ($urandom_range(0, 9)) inside
            0, 1, 2, 3: value = $urandom();
            4, 5:       value = $urandom_range(0, 99);
            6:          value = 32'd0;
            7:          value = 32'd0 - $urandom_range(1, 1000);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    default: value = 32'h8000_0001;
                endcase
            end
            default:
            begin
                value = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    value = value - 32'd1;
            end
        endcase

        if ($urandom_range(0, 9) == 0)
            conversion = 3'($urandom_range(CONV_SPARE5, CONV_SPARE7));
        else
            conversion = 3'($urandom_range(CONV_SDEC, CONV_OCT));

        // Mostly short fields; wide ones are slow and kept rare.
        if ($urandom_range(0, 19) == 0)
            field_width = 7'($urandom_range(17, WIDTH_TOP));
        else
            field_width = 7'($urandom_range(0, 16));

        send_number(value, conversion, field_width,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Stimulus: directed corners, then random requests.
    initial
    begin : stimulus
        rst_n                 = 1'b0;
        quiet_tail            = 1'b0;
        sender_gappy          = 1'b1;
        requests_sent         = 0;
        directed_sent         = 0;
        full_width_sent       = 0;
        foreach (conv_count[i])
            conv_count[i] = 0;
        number_if.valid       = 1'b0;
        number_if.value       = 32'd0;
        number_if.conversion  = CONV_SDEC;
        number_if.field_width = 7'd0;
        number_if.zero_pad    = 1'b0;
        number_if.hex_prefix  = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero prints a single '0'; a hex prefix on zero is dropped.
        send_number(32'd0, CONV_SDEC, 7'd0, 1'b0, 1'b0);          pace_sender();
        send_number(32'd0, CONV_LHEX, 7'd6, 1'b1, 1'b1);          pace_sender();
        send_number(32'd0, CONV_UHEX, 7'd4, 1'b0, 1'b1);          pace_sender();
        // Most negative value, -1 in every radix, most positive signed value
        send_number(32'h8000_0000, CONV_SDEC, 7'd0, 1'b0, 1'b0);  pace_sender();
        send_number(32'hFFFF_FFFF, CONV_SDEC, 7'd5, 1'b1, 1'b1);  pace_sender();
        send_number(32'hFFFF_FFFF, CONV_UDEC, 7'd0, 1'b0, 1'b1);  pace_sender();
        send_number(32'hFFFF_FFFF, CONV_LHEX, 7'd0, 1'b0, 1'b1);  pace_sender();
        send_number(32'hFFFF_FFFF, CONV_UHEX, 7'd0, 1'b0, 1'b1);  pace_sender();
        send_number(32'hFFFF_FFFF, CONV_OCT, 7'd0, 1'b0, 1'b0);   pace_sender();
        send_number(32'h7FFF_FFFF, CONV_SDEC, 7'd11, 1'b0, 1'b0); pace_sender();
        // Prefix with zero padding and with space padding
        send_number(32'hDEAD_BEEF, CONV_LHEX, 7'd12, 1'b1, 1'b1); pace_sender();
        send_number(32'hDEAD_BEEF, CONV_UHEX, 7'd12, 1'b0, 1'b1); pace_sender();
        // Sign with zero padding and with space padding
        send_number(32'd0 - 32'd42, CONV_SDEC, 7'd8, 1'b1, 1'b0); pace_sender();
        send_number(32'd0 - 32'd42, CONV_SDEC, 7'd8, 1'b0, 1'b0); pace_sender();
        // Prefix request ignored outside hex
        send_number(32'd12345, CONV_OCT, 7'd9, 1'b1, 1'b1);       pace_sender();
        send_number(32'd12345, CONV_UDEC, 7'd3, 1'b0, 1'b1);      pace_sender();
        // Spare conversion codes
        send_number(32'hAAAA_AAAA, CONV_SPARE5, 7'd0, 1'b0, 1'b1); pace_sender();
        send_number(32'h5555_5555, CONV_SPARE6, 7'd2, 1'b1, 1'b0); pace_sender();
        send_number(32'h8000_0000, CONV_SPARE7, 7'd1, 1'b0, 1'b1); pace_sender();
        // Full width and saturation above it
        send_number(32'h5555_5555, CONV_LHEX, 7'(MAX_WIDTH), 1'b1, 1'b1); pace_sender();
        send_number(32'hAAAA_AAAA, CONV_SDEC, 7'(MAX_WIDTH + 1), 1'b0, 1'b0); pace_sender();
        send_number(32'h0000_0007, CONV_OCT, WIDTH_TOP, 1'b1, 1'b0); pace_sender();
        send_number(32'hCAFE_F00D, CONV_UHEX, WIDTH_TOP, 1'b0, 1'b1); pace_sender();
        directed_sent = requests_sent;

        // Let the block drain completely before the random part.
        wait_text_drained();

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Every 30 requests, pick at random whether the sender leaves gaps.
            if (i % 30 == 0)
                sender_gappy = $urandom_range(0, 2) != 0;
            if (i == RANDOM_REQUESTS - QUIET_TAIL)
                quiet_tail = 1'b1;
            if (i == RANDOM_REQUESTS / 2)
                wait_text_drained();
            send_random_number();
            pace_sender();
        end

        number_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (formatted.pending_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d directed), %0d characters, %0d at full width",
                 requests_sent, directed_sent, formatted.chars_checked, full_width_sent);
        $display("By conversion: sdec %0d, udec %0d, lhex %0d, uhex %0d, oct %0d, spare %0d",
                 conv_count[CONV_SDEC], conv_count[CONV_UDEC], conv_count[CONV_LHEX],
                 conv_count[CONV_UHEX], conv_count[CONV_OCT],
                 conv_count[CONV_SPARE5] + conv_count[CONV_SPARE6] + conv_count[CONV_SPARE7]);
        if (formatted.mismatches == 0 && formatted.pending_chars.size() == 0)
            $display("tb: success");
        else
        begin
            if (formatted.pending_chars.size() != 0)
                $error("%0d characters never arrived", formatted.pending_chars.size());
            $display("tb: failure");
        end
        $finish;
    end

    // Text receiver: ready drops in random bursts; some stretches never stall.
    initial
    begin : text_receiver
        int stall_left;
        int stretch_left;
        int stall_odds;

        text_if.ready = 1'b0;
        stall_left    = 0;
        stretch_left  = 0;
        stall_odds    = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 200);
                stall_odds   = $urandom_range(0, 4);
            end
            stretch_left--;
            if (stall_left == 0 && !quiet_tail && $urandom_range(0, 15) < stall_odds)
                stall_left = $urandom_range(1, 10);
            if (stall_left != 0)
            begin
                text_if.ready <= 1'b0;
                stall_left--;
            end
            else
                text_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Check accepted characters and watch for a hung handshake. Values read
    // here are the ones present at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
                formatted.check_char(text_if.char_code, text_if.last_char);
            if ((text_if.valid && text_if.ready) || (number_if.valid && number_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no handshake for %0d cycles", idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule
